// File: src/bstk_pkg.sv
// Shared constants, word types and control structures for the bounded stack.
// Used by every module of the bounded_stack_with_stats block; no dependencies.
`default_nettype none

package bstk_pkg;

  localparam int DEPTH = 64;
  localparam int DataW = 32;
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SumW  = DataW + AddrW;
  localparam int IterW = $clog2(SumW + 1);

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } bstk_op_e;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [DataW-1:0] push_value;
  } bstk_in_t;

  typedef struct packed {
    logic                    ok;
    logic signed [DataW-1:0] read_value;
    logic [CntW-1:0]         count;
    logic signed [DataW-1:0] top_value;
    logic signed [DataW-1:0] max_value;
    logic signed [DataW-1:0] min_value;
    logic signed [DataW-1:0] mean_value;
    logic                    is_empty;
    logic                    is_full;
  } bstk_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic update;
    logic stats;
    logic load_out;
  } bstk_ctrl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_done;
  } bstk_stat_t;

endpackage

`default_nettype wire

// File: src/bounded_stack_with_stats.sv
// Top level of the bounded LIFO stack with count, top, max, min and mean reporting.
// Depends on bstk_pkg, bstk_ctrl, bstk_dp (which holds bstk_div).
//
//   Channel  Handshake                Word
//   -------  -----------------------  -----------------------------------------
//   in       in_valid_i / in_ready_o  bstk_in_t:  cmd, push_value
//   out      out_valid_o/out_ready_i  bstk_out_t: ok, read_value, count, top,
//                                     max, min, mean, is_empty, is_full
//
// Each word's result is presented once two memory read turns around the
// update and then the serial divider that forms the mean, one quotient bit
// per cycle, have run. A new word is accepted only after the previous
// word's result has been moved into the output register.
// Reset clears the count and running sum at once; the memories need no
// clearing pass because only levels below the count are ever used.
// A finished result waits in the output register while the next word is
// accepted; the block stalls before delivering a result only if the previous
// one has still not been taken.
`default_nettype none

module bounded_stack_with_stats (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire bstk_pkg::bstk_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output bstk_pkg::bstk_out_t      out_data_o
);
  import bstk_pkg::*;

  // Commands from the controller and status back from the datapath.
  bstk_ctrl_t ctrl;
  bstk_stat_t stat;

  // The controller walks every word through the same fixed sequence and
  // only waits on the divider and on the output register.
  bstk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl),
    .stat_i      (stat)
  );

  // The datapath keeps per-level running maxima and minima, so the extremes
  // of the occupied entries come from a single read at the top level.
  bstk_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .ctrl_i     (ctrl),
    .stat_o     (stat)
  );

endmodule

`default_nettype wire

// File: src/bstk_div.sv
// Iterative restoring divider: signed running sum over unsigned count, one bit a cycle.
// Depends on bstk_pkg.
`default_nettype none

module bstk_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic signed [bstk_pkg::SumW-1:0] dividend_i,
  input  wire logic [bstk_pkg::CntW-1:0]        divisor_i,
  output logic                                  done_o,
  output logic [bstk_pkg::DataW-1:0]            quotient_o
);
  import bstk_pkg::*;

  logic [SumW-1:0]  quo_q;
  logic [CntW:0]    rem_q;
  logic [CntW-1:0]  dsr_q;
  logic             neg_q;
  logic [IterW-1:0] iter_q;
  logic             busy_q;
  logic             done_q;

  logic [CntW:0]    shifted;
  logic             fits;
  logic [SumW-1:0]  mag;

  assign mag     = dividend_i[SumW-1] ? (~dividend_i + SumW'(1)) : dividend_i;
  assign shifted = {rem_q[CntW-1:0], quo_q[SumW-1]};
  assign fits    = (shifted >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= IterW'(SumW);
      end else if (busy_q) begin
        iter_q <= iter_q - IterW'(1);
        if (iter_q == IterW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag;
      rem_q <= '0;
      dsr_q <= divisor_i;
      neg_q <= dividend_i[SumW-1];
    end else if (busy_q) begin
      rem_q <= fits ? (shifted - {1'b0, dsr_q}) : shifted;
      quo_q <= {quo_q[SumW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q[DataW-1:0] + DataW'(1)) : quo_q[DataW-1:0];

endmodule

`default_nettype wire

// File: src/bstk_ctrl.sv
// Sequencing state machine for the stack: read, update, re-read, latch stats, divide, deliver.
// Depends on bstk_pkg.
`default_nettype none

module bstk_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output bstk_pkg::bstk_ctrl_t      ctrl_o,
  input  wire bstk_pkg::bstk_stat_t stat_i
);
  import bstk_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_REREAD,
    ST_STATS,
    ST_DIVIDE,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign load       = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign ctrl_o.capture  = in_ready_o && in_valid_i;
  assign ctrl_o.update   = (state_q == ST_UPDATE);
  assign ctrl_o.stats    = (state_q == ST_STATS);
  assign ctrl_o.load_out = load;
  assign out_valid_o     = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_READ;
        end
        ST_READ:   state_q <= ST_UPDATE;
        ST_UPDATE: state_q <= ST_REREAD;
        ST_REREAD: state_q <= ST_STATS;
        ST_STATS:  state_q <= ST_DIVIDE;
        ST_DIVIDE: begin
          if (stat_i.div_done) state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (load) state_q <= ST_IDLE;
        end
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/bstk_dp.sv
// Stack datapath: entry and running max/min memories, count, running sum, result word.
// Depends on bstk_pkg and bstk_div.
`default_nettype none

module bstk_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bstk_pkg::bstk_in_t   in_data_i,
  output bstk_pkg::bstk_out_t       out_data_o,
  input  wire bstk_pkg::bstk_ctrl_t ctrl_i,
  output bstk_pkg::bstk_stat_t      stat_o
);
  import bstk_pkg::*;

  logic signed [DataW-1:0] ent_mem [DEPTH];
  logic signed [DataW-1:0] max_mem [DEPTH];
  logic signed [DataW-1:0] min_mem [DEPTH];

  logic signed [DataW-1:0] ent_rd_q, max_rd_q, min_rd_q;
  bstk_in_t                item_q;
  logic [CntW-1:0]         cnt_q;
  logic signed [SumW-1:0]  sum_q;
  logic                    ok_q;
  logic signed [DataW-1:0] rdv_q, top_q, max_q, min_q;
  bstk_out_t               res_q;

  logic [CntW-1:0]         cnt_m1;
  logic [AddrW-1:0]        rd_addr;
  logic                    empty, full;
  logic                    push_ok, pop_ok, peek_ok;
  logic signed [DataW-1:0] wr_max, wr_min;
  logic signed [SumW-1:0]  val_ext, rd_ext;
  logic [DataW-1:0]        quotient;
  logic                    div_done;

  assign cnt_m1  = cnt_q - CntW'(1);
  assign rd_addr = cnt_m1[AddrW-1:0];
  assign empty   = (cnt_q == '0);
  assign full    = (cnt_q == CntW'(DEPTH));

  always_comb begin
    push_ok = 1'b0;
    pop_ok  = 1'b0;
    peek_ok = 1'b0;
    case (item_q.cmd)
      CMD_PUSH: push_ok = !full;
      CMD_POP:  pop_ok  = !empty;
      CMD_PEEK: peek_ok = !empty;
      default: ;
    endcase
  end

  // The level below supplies the running extremes; an empty stack has none.
  assign wr_max = (!empty && (max_rd_q > item_q.push_value)) ? max_rd_q : item_q.push_value;
  assign wr_min = (!empty && (min_rd_q < item_q.push_value)) ? min_rd_q : item_q.push_value;

  assign val_ext = {{(SumW-DataW){item_q.push_value[DataW-1]}}, item_q.push_value};
  assign rd_ext  = {{(SumW-DataW){ent_rd_q[DataW-1]}}, ent_rd_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.update && push_ok) begin
      ent_mem[cnt_q[AddrW-1:0]] <= item_q.push_value;
      max_mem[cnt_q[AddrW-1:0]] <= wr_max;
      min_mem[cnt_q[AddrW-1:0]] <= wr_min;
    end
    ent_rd_q <= ent_mem[rd_addr];
    max_rd_q <= max_mem[rd_addr];
    min_rd_q <= min_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
    end else if (ctrl_i.update) begin
      if (push_ok) begin
        cnt_q <= cnt_q + CntW'(1);
        sum_q <= sum_q + val_ext;
      end else if (pop_ok) begin
        cnt_q <= cnt_m1;
        sum_q <= sum_q - rd_ext;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      item_q <= in_data_i;
    end
    if (ctrl_i.update) begin
      ok_q  <= push_ok || pop_ok || peek_ok;
      rdv_q <= (pop_ok || peek_ok) ? ent_rd_q : '0;
    end
    if (ctrl_i.stats) begin
      top_q <= empty ? '0 : ent_rd_q;
      max_q <= empty ? '0 : max_rd_q;
      min_q <= empty ? '0 : min_rd_q;
    end
    if (ctrl_i.load_out) begin
      res_q.ok         <= ok_q;
      res_q.read_value <= rdv_q;
      res_q.count      <= cnt_q;
      res_q.top_value  <= top_q;
      res_q.max_value  <= max_q;
      res_q.min_value  <= min_q;
      res_q.mean_value <= empty ? '0 : quotient;
      res_q.is_empty   <= empty;
      res_q.is_full    <= full;
    end
  end

  bstk_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.stats),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign stat_o.div_done = div_done;
  assign out_data_o      = res_q;

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the bounded stack with count, top, max, min and mean.
// Holds its own stack predictor in a small scoreboard class and drives both handshakes.
// Depends on bstk_pkg and bounded_stack_with_stats only.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bstk_pkg::*;

  // The fourth command code has no operation behind it and must leave the stack alone.
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic [31:0] IntMax = 32'h7fff_ffff;
  localparam logic [31:0] IntMin = 32'h8000_0000;

  localparam int RandomWords = 900;

  typedef enum int {
    BURST_MIX,
    BURST_FILL,
    BURST_DRAIN,
    BURST_SAWTOOTH
  } burst_kind_e;

  typedef enum int {
    VAL_ANY,
    VAL_EXTREME,
    VAL_NARROW
  } value_style_e;

  // Scoreboard: mirrors the stack as each input word is accepted, queues the
  // result word that the step must produce, and compares arriving results in order.
  class stack_scoreboard;
    logic signed [31:0] held_values[DEPTH];
    logic signed [31:0] peak_upto[DEPTH];
    logic signed [31:0] trough_upto[DEPTH];
    int                 held;
    longint             level_sum;
    bstk_out_t          expected_results[$];
    int                 errors;
    int                 checked;
    string              diff_text;

    function new();
      held      = 0;
      level_sum = 0;
      errors    = 0;
      checked   = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task log_mismatch(string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      errors++;
    endtask

    // Apply one accepted command to the mirror and queue the result it implies.
    function void note_word(bstk_in_t w);
      bstk_out_t          want;
      logic signed [31:0] value;
      logic signed [31:0] hi;
      logic signed [31:0] lo;
      longint             quotient;

      want  = '0;
      value = w.push_value;
      case (w.cmd)
        CMD_PUSH: begin
          if (held < DEPTH) begin
            hi = value;
            lo = value;
            if (held > 0) begin
              if (peak_upto[held-1] > hi) hi = peak_upto[held-1];
              if (trough_upto[held-1] < lo) lo = trough_upto[held-1];
            end
            held_values[held] = value;
            peak_upto[held]   = hi;
            trough_upto[held] = lo;
            held++;
            level_sum += value;
            want.ok = 1'b1;
          end
        end
        CMD_POP: begin
          if (held > 0) begin
            held--;
            want.read_value = held_values[held];
            level_sum -= held_values[held];
            want.ok = 1'b1;
          end
        end
        CMD_PEEK: begin
          if (held > 0) begin
            want.read_value = held_values[held-1];
            want.ok = 1'b1;
          end
        end
        default: begin
          // Unused code: fails, status still reports the unchanged stack.
        end
      endcase

      want.count = held[CntW-1:0];
      if (held > 0) begin
        quotient        = level_sum / longint'(held);
        want.top_value  = held_values[held-1];
        want.max_value  = peak_upto[held-1];
        want.min_value  = trough_upto[held-1];
        want.mean_value = quotient[31:0];
      end
      want.is_empty = (held == 0);
      want.is_full  = (held == DEPTH);
      expected_results.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        diff_text = {diff_text, $sformatf(" %s got %h want %h", name, got, want)};
      end
    endfunction

    task check_word(bstk_out_t got);
      bstk_out_t want;

      if (expected_results.size() == 0) begin
        log_mismatch("result word arrived with nothing expected");
        return;
      end
      want      = expected_results.pop_front();
      diff_text = "";
      compare_field("ok", got.ok, want.ok);
      compare_field("read_value", got.read_value, want.read_value);
      compare_field("count", got.count, want.count);
      compare_field("top_value", got.top_value, want.top_value);
      compare_field("max_value", got.max_value, want.max_value);
      compare_field("min_value", got.min_value, want.min_value);
      compare_field("mean_value", got.mean_value, want.mean_value);
      compare_field("is_empty", got.is_empty, want.is_empty);
      compare_field("is_full", got.is_full, want.is_full);
      if (diff_text != "") begin
        log_mismatch($sformatf("result %0d:%s", checked, diff_text));
      end
      checked++;
    endtask
  endclass

  // Every input of the block starts from a known value at time zero.
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  bstk_in_t  in_data_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  bstk_out_t out_data_o;

  stack_scoreboard sb = new();

  // Set per burst: a calm burst offers words back to back.
  bit sender_calm;

  always #5ns clk_i = ~clk_i;

  bounded_stack_with_stats i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Most words follow with no gap; now and then a long gap lands on
  // a different phase of the serial mean division.
  function int pick_gap();
    int r;
    r = $urandom_range(99);
    if (sender_calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function logic [31:0] pick_value(value_style_e style);
    int r;
    r = $urandom_range(99);
    case (style)
      VAL_EXTREME: return $urandom_range(1) ? IntMax : IntMin;
      VAL_NARROW:  return 32'($urandom_range(200)) - 32'd100;
      default: begin
        if (r < 4) return IntMax;
        if (r < 8) return IntMin;
        return $urandom;
      end
    endcase
  endfunction

  // Present one word, hold it until the block takes it, then note it in the
  // scoreboard in the same time step as the accepting edge.
  task send_word(logic [1:0] cmd, logic [31:0] value);
    bstk_in_t w;
    int       gap;

    w.cmd        = cmd;
    w.push_value = value;
    in_data_i  <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
    gap = pick_gap();
    // Valid is only dropped when a real gap follows, so it never gets two updates in one step.
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Result side: random back-pressure, calm stretches, and two long hold-offs
  // that let the block fill up and refuse input while the sender keeps offering.
  initial begin : result_sink
    int hold_left;
    int calm_left;
    int taken;
    int r;

    hold_left = 0;
    calm_left = 0;
    taken     = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_word(out_data_o);
        taken++;
        if (taken == 200 || taken == 650) hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          r = $urandom_range(99);
          if (r < 5) calm_left = $urandom_range(50, 300);
          else if (r < 55) hold_left = 0;
          else if (r < 93) hold_left = $urandom_range(1, 3);
          else hold_left = $urandom_range(10, 60);
        end
      end
    end
  end

  initial begin : stimulus
    int           sent;
    int           burst_len;
    int           r;
    burst_kind_e  kind;
    value_style_e style;
    logic [1:0]   cmd;
    int           guard;

    sent        = 0;
    sender_calm = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: commands on an empty stack, the unused code both ways,
    // the extreme values, truncation of a negative mean, and sums at both extremes.
    send_word(CMD_PEEK, 32'd0);
    send_word(CMD_POP, 32'hdead_beef);
    send_word(CmdUnused, 32'hffff_ffff);
    send_word(CMD_PUSH, IntMax);
    send_word(CMD_PUSH, IntMin);
    send_word(CMD_PEEK, 32'h5555_5555);
    send_word(CmdUnused, 32'd0);
    send_word(CMD_PUSH, -32'sd7);
    send_word(CMD_PUSH, 32'd2);
    repeat (4) send_word(CMD_POP, 32'd0);
    send_word(CMD_POP, 32'd0);
    repeat (3) send_word(CMD_PUSH, IntMax);
    repeat (3) send_word(CMD_POP, 32'd0);
    repeat (2) send_word(CMD_PUSH, IntMin);
    repeat (2) send_word(CMD_POP, 32'd0);

    // Random bursts. Filling and draining runs are what reach the full and
    // empty boundaries; mixed and sawtooth runs shuffle the statistics around.
    while (sent < RandomWords) begin
      r           = $urandom_range(99);
      kind        = (r < 35) ? BURST_MIX : (r < 55) ? BURST_FILL :
                    (r < 75) ? BURST_DRAIN : BURST_SAWTOOTH;
      r           = $urandom_range(99);
      style       = (r < 60) ? VAL_ANY : (r < 75) ? VAL_EXTREME : VAL_NARROW;
      sender_calm = ($urandom_range(99) < 25);
      case (kind)
        BURST_FILL: begin
          while (sb.held < DEPTH) begin
            cmd = ($urandom_range(99) < 8) ? CMD_PEEK : CMD_PUSH;
            send_word(cmd, pick_value(style));
            sent++;
          end
          // Pushes against a full stack must fail without touching it.
          burst_len = $urandom_range(1, 3);
          repeat (burst_len) begin
            send_word(CMD_PUSH, pick_value(style));
            sent++;
          end
        end
        BURST_DRAIN: begin
          while (sb.held > 0) begin
            cmd = ($urandom_range(99) < 8) ? CMD_PEEK : CMD_POP;
            send_word(cmd, $urandom);
            sent++;
          end
          burst_len = $urandom_range(1, 3);
          repeat (burst_len) begin
            cmd = $urandom_range(1) ? CMD_PEEK : CMD_POP;
            send_word(cmd, $urandom);
            sent++;
          end
        end
        BURST_SAWTOOTH: begin
          burst_len = $urandom_range(20, 40);
          for (int i = 0; i < burst_len; i++) begin
            cmd = (i % 2 == 0) ? CMD_PUSH : CMD_POP;
            send_word(cmd, pick_value(style));
            sent++;
          end
        end
        default: begin
          burst_len = $urandom_range(10, 40);
          repeat (burst_len) begin
            r   = $urandom_range(99);
            cmd = (r < 45) ? CMD_PUSH : (r < 75) ? CMD_POP : (r < 94) ? CMD_PEEK : CmdUnused;
            send_word(cmd, pick_value(style));
            sent++;
          end
        end
      endcase
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every outstanding result, then a little past the latency
    // of one word to catch anything unexpected trailing behind.
    guard = 0;
    while (sb.pending() > 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (60) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.log_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
    end

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run, stalls and hold-offs included.
  initial begin : watchdog
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: files.f
src/bstk_pkg.sv
src/bstk_div.sv
src/bstk_ctrl.sv
src/bstk_dp.sv
src/bounded_stack_with_stats.sv
dv/testbench.sv
